// ===== rtl/grid_ray_wall_caster_unit_defines.svh =====
// Assertion macros shared by the ray caster RTL.
`ifndef GRID_RAY_WALL_CASTER_UNIT_DEFINES_SVH
`define GRID_RAY_WALL_CASTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GRWC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grwc: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define GRWC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grwc: next-cycle check failed");

`endif

// ===== rtl/grwc_pkg.sv =====
// Types, constants and the sine table of the grid ray wall caster.
package grwc_pkg;

  localparam int MAP_SIDE_DEF  = 32;
  localparam int MAX_STEPS_DEF = 8;

  // Texel grid across one wall face; the column port is TEX_BITS wide.
  localparam int TEX_SIZE = 16;
  localparam int TEX_BITS = 4;
  localparam int TEX_LSB  = 16 - TEX_BITS;

  localparam int SIN_W       = 31;
  localparam int SIN_ENTRIES = 1025;
  localparam int SLOPE_W     = 29;
  localparam int NW          = 40;

  localparam logic [SLOPE_W-1:0] SLOPE_MAX = 29'h1000_0000;
  localparam logic [19:0]        DIST_MAX  = 20'hF_FFFF;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CAST  = 1'b1;

  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SIN_RD,
    ST_COS_RD,
    ST_COS_CAP,
    ST_PASS_START,
    ST_DIV,
    ST_OFFS_MUL,
    ST_N0_SET,
    ST_STEP_ADDR,
    ST_STEP_CHECK,
    ST_DSQ_A,
    ST_DSQ_B,
    ST_SQ_SUM,
    ST_SQRT,
    ST_PASS_END,
    ST_FISH_RD,
    ST_FISH_CAP,
    ST_PERP_MUL,
    ST_PERP_DONE
  } state_t;

  typedef struct packed {
    logic [10:0] q;
    logic        neg;
  } sine_addr_t;

  typedef logic [SIN_W-1:0] sin_rom_t [SIN_ENTRIES];

  // Folds a binary angle onto the quarter wave and gives the sign of the sine.
  function automatic sine_addr_t sine_addr(input logic [11:0] a);
    sine_addr_t r;
    r.neg = (a > 12'd2048);
    if (a < 12'd1024) begin
      r.q = {1'b0, a[9:0]};
    end else if (a < 12'd2048) begin
      r.q = 11'(13'd2048 - {1'b0, a});
    end else if (a < 12'd3072) begin
      r.q = 11'({1'b0, a} - 13'd2048);
    end else begin
      r.q = 11'(13'd4096 - {1'b0, a});
    end
    return r;
  endfunction

  // Quarter-wave sine in Q30, evaluated once at elaboration.
  function automatic sin_rom_t build_sin_rom();
    sin_rom_t    t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] u;
    for (int q = 0; q < SIN_ENTRIES; q++) begin
      x  = (64'(q) * 64'd3373259426 + 64'd1024) >> 11;
      x2 = (x * x) >> 30;
      u  = 64'd1073741824 - x2 / 64'd110;
      u  = 64'd1073741824 - ((x2 * u) >> 30) / 64'd72;
      u  = 64'd1073741824 - ((x2 * u) >> 30) / 64'd42;
      u  = 64'd1073741824 - ((x2 * u) >> 30) / 64'd20;
      u  = 64'd1073741824 - ((x2 * u) >> 30) / 64'd6;
      t[q] = SIN_W'((x * u) >> 30);
    end
    return t;
  endfunction

  localparam sin_rom_t SIN_ROM = build_sin_rom();

endpackage

// ===== rtl/grid_ray_wall_caster_unit.sv =====
// Grid ray caster: map store, gridline walk and hit distance sequencer.
//
// Input channel (in_valid/in_ready): one beat is a write or a cast. A write beat
// (func 0) stores cell_value at cell_index as soon as it is taken; an
// address at or beyond MAP_SIDE*MAP_SIDE is dropped. A cast beat (func 1) walks
// the ray through horizontal and then vertical gridlines and yields one result
// beat; in_ready stays low while a cast is in progress.
// Output channel (out_valid/out_ready): a result register holds the beat until
// it is taken. Write beats are still taken while a result waits; a finished
// cast that finds the result register full waits in its last step.
// A new cast beat is taken only once the previous cast has left its last step,
// since in_ready is high only while the sequencer is idle.
// A walk that is not skipped runs the bit-serial slope divider unless the slope
// saturates, steps each gridline crossing as an address step and then the
// registered map read, and takes the bit-pair square root on a hit; the sine
// table is a registered ROM read three times.
// Map size registers take cfg_write/cfg_index/cfg_data at any edge out of reset.
// Reset (rst, synchronous) returns the sequencer to idle, drops a pending
// result and sets both map size registers to 32. The map store is not cleared.
`include "grid_ray_wall_caster_unit_defines.svh"

module grid_ray_wall_caster_unit #(
  parameter int MAP_SIDE  = grwc_pkg::MAP_SIDE_DEF,
  parameter int MAX_STEPS = grwc_pkg::MAX_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [9:0]  cell_index,
  input  logic [7:0]  cell_value,
  input  logic [15:0] player_x,
  input  logic [15:0] player_y,
  input  logic [11:0] ray_angle,
  input  logic [11:0] view_angle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [19:0] ray_distance,
  output logic [19:0] perp_distance,
  output logic [7:0]  wall_code,
  output logic        side,
  output logic [3:0]  texture_column
);

  localparam int DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(DEPTH);
  // One bit above the address so the store depth itself can be compared.
  localparam int IXW   = ((AW > 10) ? AW : 10) + 1;
  localparam int SCW   = $clog2(MAX_STEPS + 1);
  localparam int NW    = grwc_pkg::NW;

  // Clamps a Q16 delta to 2^27 in magnitude and returns the magnitude.
  function automatic logic [27:0] clamp_mag(input logic signed [40:0] d);
    logic signed [40:0] m;
    m = d[40] ? -d : d;
    return (m > 41'sd134217728) ? 28'd134217728 : m[27:0];
  endfunction

  grwc_pkg::state_t state, state_next;

  logic [5:0] map_width, map_height;
  logic [6:0] lim_w, lim_h;

  logic [15:0] px, py;
  logic [11:0] ang, view;
  logic [30:0] smag, cmag, fmag;
  logic        sneg, cneg, fneg;
  logic        pass;

  // Map store and sine ROM, both with registered reads.
  logic [7:0]  wall_map [DEPTH];
  logic [7:0]  mem_q;
  logic [AW-1:0] rd_addr;
  logic        mem_we;
  logic [IXW-1:0] wr_idx;
  logic [30:0] rom_q;
  logic        rom_neg;
  logic [11:0] rom_angle;
  grwc_pkg::sine_addr_t rom_sa;

  // Per-walk selections.
  logic [15:0] pmaj, pmin;
  logic [20:0] pmaj_q16, pmin_q16;
  logic [6:0]  lim_m, lim_n;
  logic        dir_neg, skip, mirror, sl_neg;
  logic [30:0] num, den;
  logic        div_sat;
  logic [15:0] frac;
  logic [16:0] off_mag;
  logic        off_neg;
  logic signed [8:0] line0;

  // Divider.
  logic [30:0] div_rem;
  logic [28:0] div_low, div_q;
  logic [31:0] div_t;
  logic        div_bit;
  logic [28:0] div_q_next;
  logic [4:0]  iter;
  logic [grwc_pkg::SLOPE_W-1:0] sl_mag;

  // Walk.
  logic signed [8:0]    line_l, cm;
  logic signed [NW-1:0] n_cur, step_v, n0, adj;
  logic [46:0]          up_sum;
  logic [SCW-1:0]       step_cnt;
  logic                 outside;
  logic [5:0]           cn;

  // Shared multiplier.
  logic        mul_en;
  logic [29:0] mul_a;
  logic [30:0] mul_b;
  logic [60:0] mul_p;

  // Square root.
  logic signed [40:0] dm, dn;
  logic [55:0] sq_acc, sq_bit;
  logic [56:0] sq_v, sq_r, sq_t;

  // Per-walk hit records: index 0 horizontal, 1 vertical.
  logic        hit_f  [2];
  logic [27:0] dist_f [2];
  logic [7:0]  code_f [2];
  logic [3:0]  tex_f  [2];

  logic        use_v, any_hit, out_free;
  logic [27:0] d_sel;
  logic [19:0] ray_sat, perp_sat;

  assign lim_w = (7'(map_width) > 7'(MAP_SIDE)) ? 7'(MAP_SIDE) : 7'(map_width);
  assign lim_h = (7'(map_height) > 7'(MAP_SIDE)) ? 7'(MAP_SIDE) : 7'(map_height);

  // The horizontal walk steps along y and looks up cot; the vertical one along x
  // with tan.
  always_comb begin
    if (!pass) begin
      pmaj    = py;
      pmin    = px;
      lim_m   = lim_h;
      lim_n   = lim_w;
      dir_neg = (ang > 12'd2048);
      num     = cmag;
      den     = smag;
      skip    = (ang == 12'd0) || (ang == 12'd2048);
      mirror  = (ang < 12'd2048);
    end else begin
      pmaj    = px;
      pmin    = py;
      lim_m   = lim_w;
      lim_n   = lim_h;
      dir_neg = (ang > 12'd1024) && (ang < 12'd3072);
      num     = smag;
      den     = cmag;
      skip    = (ang == 12'd1024) || (ang == 12'd3072);
      mirror  = dir_neg;
    end
  end

  assign pmaj_q16 = {pmaj, 5'd0};
  assign pmin_q16 = {pmin, 5'd0};
  assign sl_neg   = sneg ^ cneg;
  assign div_sat  = (den == 31'd0) || ({13'd0, num[30:13]} >= den);
  assign frac     = {pmaj[10:0], 5'd0};
  assign off_mag  = dir_neg ? {1'b0, frac} : (17'h1_0000 - {1'b0, frac});
  assign off_neg  = dir_neg && (frac != 16'd0);
  assign line0    = $signed({4'd0, pmaj[15:11]}) + (dir_neg ? 9'sd0 : 9'sd1);

  assign div_t      = {div_rem, div_low[28]};
  assign div_bit    = (div_t >= {1'b0, den});
  assign div_q_next = {div_q[27:0], div_bit};

  // First crossing: floor of the signed offset times slope over 2^16.
  assign up_sum = {1'b0, mul_p[45:0]} + 47'd65535;
  assign adj    = (off_neg ^ sl_neg) ? -$signed({9'd0, up_sum[46:16]})
                                     : $signed({10'd0, mul_p[45:16]});
  assign n0     = $signed({19'd0, pmin_q16}) + adj;
  assign step_v = (sl_neg ^ dir_neg) ? -$signed({11'd0, sl_mag})
                                     : $signed({11'd0, sl_mag});

  assign cm      = dir_neg ? (line_l - 9'sd1) : line_l;
  assign outside = cm[8] || (cm[7:0] >= {1'b0, lim_m}) ||
                   n_cur[NW-1] || (n_cur[38:16] >= {16'd0, lim_n});
  assign cn      = n_cur[21:16];
  assign rd_addr = !pass ? (AW'(cm[7:0]) * AW'(MAP_SIDE) + AW'(cn))
                         : (AW'(cn) * AW'(MAP_SIDE) + AW'(cm[7:0]));

  assign dm = $signed({{16{line_l[8]}}, line_l, 16'd0}) - $signed({20'd0, pmaj_q16});
  assign dn = $signed({n_cur[NW-1], n_cur}) - $signed({20'd0, pmin_q16});

  assign sq_t = sq_r + {1'b0, sq_bit};

  assign any_hit  = hit_f[0] || hit_f[1];
  assign use_v    = hit_f[1] && (!hit_f[0] || (dist_f[1] < dist_f[0]));
  assign d_sel    = use_v ? dist_f[1] : dist_f[0];
  assign ray_sat  = (|d_sel[27:26]) ? grwc_pkg::DIST_MAX : d_sel[25:6];
  assign perp_sat = fneg ? 20'd0 :
                    ((|mul_p[60:56]) ? grwc_pkg::DIST_MAX : mul_p[55:36]);
  assign out_free = !out_valid || out_ready;

  assign wr_idx = IXW'(cell_index);
  assign rom_sa = grwc_pkg::sine_addr(rom_angle);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      grwc_pkg::ST_IDLE: begin
        if (in_valid && (func == grwc_pkg::FUNC_CAST)) state_next = grwc_pkg::ST_SIN_RD;
      end
      grwc_pkg::ST_SIN_RD:  state_next = grwc_pkg::ST_COS_RD;
      grwc_pkg::ST_COS_RD:  state_next = grwc_pkg::ST_COS_CAP;
      grwc_pkg::ST_COS_CAP: state_next = grwc_pkg::ST_PASS_START;
      grwc_pkg::ST_PASS_START: begin
        priority if (skip) state_next = grwc_pkg::ST_PASS_END;
        else if (div_sat) state_next = grwc_pkg::ST_OFFS_MUL;
        else state_next = grwc_pkg::ST_DIV;
      end
      grwc_pkg::ST_DIV: begin
        if (iter == 5'd0) state_next = grwc_pkg::ST_OFFS_MUL;
      end
      grwc_pkg::ST_OFFS_MUL: state_next = grwc_pkg::ST_N0_SET;
      grwc_pkg::ST_N0_SET:   state_next = grwc_pkg::ST_STEP_ADDR;
      grwc_pkg::ST_STEP_ADDR: begin
        state_next = outside ? grwc_pkg::ST_DSQ_A : grwc_pkg::ST_STEP_CHECK;
      end
      grwc_pkg::ST_STEP_CHECK: begin
        priority if (mem_q != 8'd0) state_next = grwc_pkg::ST_DSQ_A;
        else if (step_cnt == SCW'(MAX_STEPS - 1)) state_next = grwc_pkg::ST_PASS_END;
        else state_next = grwc_pkg::ST_STEP_ADDR;
      end
      grwc_pkg::ST_DSQ_A:  state_next = grwc_pkg::ST_DSQ_B;
      grwc_pkg::ST_DSQ_B:  state_next = grwc_pkg::ST_SQ_SUM;
      grwc_pkg::ST_SQ_SUM: state_next = grwc_pkg::ST_SQRT;
      grwc_pkg::ST_SQRT: begin
        if (sq_bit[0]) state_next = grwc_pkg::ST_PASS_END;
      end
      grwc_pkg::ST_PASS_END: begin
        state_next = pass ? grwc_pkg::ST_FISH_RD : grwc_pkg::ST_PASS_START;
      end
      grwc_pkg::ST_FISH_RD:  state_next = grwc_pkg::ST_FISH_CAP;
      grwc_pkg::ST_FISH_CAP: state_next = grwc_pkg::ST_PERP_MUL;
      grwc_pkg::ST_PERP_MUL: state_next = grwc_pkg::ST_PERP_DONE;
      grwc_pkg::ST_PERP_DONE: begin
        if (out_free) state_next = grwc_pkg::ST_IDLE;
      end
      default: state_next = grwc_pkg::ST_IDLE;
    endcase
  end

  // Control outputs: handshake, store write, multiplier operands, ROM angle.
  always_comb begin
    in_ready  = (state == grwc_pkg::ST_IDLE);
    mem_we    = in_ready && in_valid && (func == grwc_pkg::FUNC_WRITE) &&
                (wr_idx < IXW'(DEPTH));
    mul_en    = 1'b0;
    mul_a     = 30'd0;
    mul_b     = 31'd0;
    rom_angle = ang;
    unique case (state)
      grwc_pkg::ST_SIN_RD: rom_angle = ang;
      grwc_pkg::ST_COS_RD: rom_angle = ang + 12'd1024;
      grwc_pkg::ST_FISH_RD: rom_angle = view - ang + 12'd1024;
      grwc_pkg::ST_OFFS_MUL: begin
        mul_en = 1'b1;
        mul_a  = 30'(off_mag);
        mul_b  = 31'(sl_mag);
      end
      grwc_pkg::ST_DSQ_A: begin
        mul_en = 1'b1;
        mul_a  = 30'(clamp_mag(dm));
        mul_b  = 31'(clamp_mag(dm));
      end
      grwc_pkg::ST_DSQ_B: begin
        mul_en = 1'b1;
        mul_a  = 30'(clamp_mag(dn));
        mul_b  = 31'(clamp_mag(dn));
      end
      grwc_pkg::ST_PERP_MUL: begin
        mul_en = 1'b1;
        mul_a  = 30'(d_sel);
        mul_b  = fmag;
      end
      default: begin
      end
    endcase
  end

  // The sign of the sine travels with the ROM word.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      wall_map[wr_idx[AW-1:0]] <= cell_value;
    end
    mem_q   <= wall_map[rd_addr];
    rom_q   <= grwc_pkg::SIN_ROM[rom_sa.q];
    rom_neg <= rom_sa.neg;
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      mul_p <= {31'd0, mul_a} * {30'd0, mul_b};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= grwc_pkg::ST_IDLE;
      out_valid  <= 1'b0;
      map_width  <= 6'd32;
      map_height <= 6'd32;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          grwc_pkg::REG_MAP_WIDTH:  map_width  <= cfg_data;
          grwc_pkg::REG_MAP_HEIGHT: map_height <= cfg_data;
          default: begin
          end
        endcase
      end
      if ((state == grwc_pkg::ST_PERP_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      grwc_pkg::ST_IDLE: begin
        if (in_valid && (func == grwc_pkg::FUNC_CAST)) begin
          px   <= player_x;
          py   <= player_y;
          ang  <= ray_angle;
          view <= view_angle;
        end
      end
      grwc_pkg::ST_SIN_RD: pass <= 1'b0;
      grwc_pkg::ST_COS_RD: begin
        smag <= rom_q;
        sneg <= rom_neg;
      end
      grwc_pkg::ST_COS_CAP: begin
        cmag <= rom_q;
        cneg <= rom_neg;
      end
      grwc_pkg::ST_PASS_START: begin
        hit_f[pass] <= 1'b0;
        div_rem     <= {13'd0, num[30:13]};
        div_low     <= {num[12:0], 16'd0};
        div_q       <= 29'd0;
        iter        <= 5'd28;
        if (div_sat) sl_mag <= grwc_pkg::SLOPE_MAX;
      end
      grwc_pkg::ST_DIV: begin
        div_rem <= div_bit ? 31'(div_t - {1'b0, den}) : div_t[30:0];
        div_low <= {div_low[27:0], 1'b0};
        div_q   <= div_q_next;
        iter    <= iter - 5'd1;
        if (iter == 5'd0) begin
          sl_mag <= (div_q_next > grwc_pkg::SLOPE_MAX) ? grwc_pkg::SLOPE_MAX : div_q_next;
        end
      end
      grwc_pkg::ST_N0_SET: begin
        n_cur    <= n0;
        line_l   <= line0;
        step_cnt <= '0;
      end
      grwc_pkg::ST_STEP_ADDR: begin
        if (outside) begin
          hit_f[pass]  <= 1'b1;
          code_f[pass] <= 8'd1;
          tex_f[pass]  <= mirror ? ~n_cur[15:grwc_pkg::TEX_LSB] : n_cur[15:grwc_pkg::TEX_LSB];
        end
      end
      grwc_pkg::ST_STEP_CHECK: begin
        if (mem_q != 8'd0) begin
          hit_f[pass]  <= 1'b1;
          code_f[pass] <= mem_q;
          tex_f[pass]  <= mirror ? ~n_cur[15:grwc_pkg::TEX_LSB] : n_cur[15:grwc_pkg::TEX_LSB];
        end else begin
          line_l   <= dir_neg ? (line_l - 9'sd1) : (line_l + 9'sd1);
          n_cur    <= n_cur + step_v;
          step_cnt <= step_cnt + SCW'(1);
        end
      end
      grwc_pkg::ST_DSQ_B: sq_acc <= mul_p[55:0];
      grwc_pkg::ST_SQ_SUM: begin
        sq_v   <= {1'b0, sq_acc} + {1'b0, mul_p[55:0]};
        sq_r   <= 57'd0;
        sq_bit <= 56'd1 << 54;
      end
      grwc_pkg::ST_SQRT: begin
        if (sq_v >= sq_t) begin
          sq_v <= sq_v - sq_t;
          sq_r <= (sq_r >> 1) + {1'b0, sq_bit};
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      grwc_pkg::ST_PASS_END: begin
        if (hit_f[pass]) dist_f[pass] <= sq_r[27:0];
        pass <= 1'b1;
      end
      grwc_pkg::ST_FISH_CAP: begin
        fmag <= rom_q;
        fneg <= rom_neg;
      end
      grwc_pkg::ST_PERP_DONE: begin
        if (out_free) begin
          hit            <= any_hit;
          ray_distance   <= any_hit ? ray_sat : 20'd0;
          perp_distance  <= any_hit ? perp_sat : 20'd0;
          wall_code      <= any_hit ? (use_v ? code_f[1] : code_f[0]) : 8'd0;
          side           <= any_hit && use_v;
          texture_column <= any_hit ? (use_v ? tex_f[1] : tex_f[0]) : 4'd0;
        end
      end
      default: begin
      end
    endcase
  end

  // The partial remainder never reaches the divisor during division.
  `GRWC_ASSERT_IMP(a_div_rem, clk, rst, state == grwc_pkg::ST_DIV, div_rem < den)
  // The root's trial bit is a single bit for as long as the root iterates.
  `GRWC_ASSERT_IMP(a_sqrt_bit, clk, rst, state == grwc_pkg::ST_SQRT, $onehot(sq_bit))
  // A cast beat closes the input until its result is formed.
  `GRWC_ASSERT_NXT(a_cast_busy, clk, rst,
                   in_valid && in_ready && (func == grwc_pkg::FUNC_CAST), !in_ready)
  // A result appears only from the last step of a cast.
  `GRWC_ASSERT_NXT(a_out_src, clk, rst,
                   !out_valid && (state != grwc_pkg::ST_PERP_DONE), !out_valid)
  // A miss carries all-zero fields.
  `GRWC_ASSERT_IMP(a_miss_zero, clk, rst, out_valid && !hit,
                   (ray_distance == 20'd0) && (wall_code == 8'd0) && !side)

endmodule
